/* rtl/ffha_pkg.sv */
// Shared constants, command and status types for the first-fit heap allocator.
// No dependencies; the controller, datapath, top level and testbench import this package.
`timescale 1ns / 1ps

package ffha_pkg;

    // Default heap geometry.
    localparam int HEAP_BYTES_DEF   = 65536;
    localparam int HEADER_BYTES_DEF = 8;

    // Fixed port widths.
    localparam int OFF_W  = 16;
    localparam int REQ_W  = 16;
    localparam int CNT_W  = 17;
    localparam int BLK_W  = 14;

    // Operation codes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Status codes.
    localparam logic ST_DONE = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr;
        logic load;
        logic rd_cur;
        logic take;
        logic step;
        logic rd_off;
        logic wr_split;
        logic wr_cur;
        logic wr_app;
        logic wr_free;
        logic fin_fail;
        logic fin_nop;
    } ffha_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic is_free_op;
        logic req_zero;
        logic free_ok;
        logic fit;
        logic split_ok;
        logic walk_end;
        logic append_ok;
    } ffha_sts_t;

endpackage

/* rtl/ffha_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ffha_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; read data holds while re is low.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/ffha_ctrl.sv */
// Controller state machine of the heap allocator: clearing pass, chain walk,
// split, commit, append and free sequencing. Depends on ffha_pkg.
`timescale 1ns / 1ps

module ffha_ctrl
    import ffha_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  ffha_sts_t sts,
    output ffha_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_WALK_RD,
        S_WALK_CHK,
        S_SPLIT,
        S_COMMIT,
        S_APPEND,
        S_FREE_RD,
        S_FREE_WR,
        S_FIN_FAIL,
        S_FIN_NOP
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   fin_ok;
    logic   finish;

    // A result may be written once the output slot is empty or being taken.
    assign fin_ok    = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign finish    = cmd.wr_cur | cmd.wr_app | cmd.wr_free | cmd.fin_fail | cmd.fin_nop;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.is_free_op)
                begin
                    state_next = sts.free_ok ? S_FREE_RD : S_FIN_NOP;
                end
                else
                begin
                    state_next = sts.req_zero ? S_FIN_FAIL : S_WALK_RD;
                end
            end
            S_WALK_RD:
            begin
                cmd.rd_cur = 1'b1;
                state_next = S_WALK_CHK;
            end
            S_WALK_CHK:
            begin
                if (sts.fit)
                begin
                    cmd.take   = 1'b1;
                    state_next = sts.split_ok ? S_SPLIT : S_COMMIT;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = sts.walk_end ? S_APPEND : S_WALK_RD;
                end
            end
            S_SPLIT:
            begin
                cmd.wr_split = 1'b1;
                state_next   = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (fin_ok)
                begin
                    cmd.wr_cur = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_APPEND:
            begin
                if (fin_ok)
                begin
                    cmd.wr_app   = sts.append_ok;
                    cmd.fin_fail = !sts.append_ok;
                    state_next   = S_IDLE;
                end
            end
            S_FREE_RD:
            begin
                cmd.rd_off = 1'b1;
                state_next = S_FREE_WR;
            end
            S_FREE_WR:
            begin
                if (fin_ok)
                begin
                    cmd.wr_free = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_FIN_FAIL:
            begin
                if (fin_ok)
                begin
                    cmd.fin_fail = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_FIN_NOP:
            begin
                if (fin_ok)
                begin
                    cmd.fin_nop = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output slot occupancy.
    assign out_valid_next = finish ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/ffha_dpath.sv */
// Datapath of the heap allocator: header RAM, walk pointer, statistics
// counters and result registers. Depends on ffha_pkg and ffha_ram.
`timescale 1ns / 1ps

module ffha_dpath
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ffha_cmd_t        cmd,
    output ffha_sts_t        sts,
    input  logic             operation,
    input  logic [REQ_W-1:0] request_size,
    input  logic [OFF_W-1:0] release_offset,
    output logic [OFF_W-1:0] payload_offset,
    output logic             status,
    output logic [CNT_W-1:0] bytes_used,
    output logic [CNT_W-1:0] bytes_free,
    output logic [BLK_W-1:0] block_count
);

    localparam int WORDS  = HEAP_BYTES / 8;
    localparam int WORD_W = $clog2(WORDS);
    localparam int LOG_H  = $clog2(HEAP_BYTES) + 1;
    localparam int SZ_W   = (LOG_H > CNT_W) ? LOG_H : CNT_W;
    localparam int ADDR_W = SZ_W + 2;
    localparam int ENT_W  = SZ_W + 1;

    localparam logic [ADDR_W-1:0] HDR_A   = ADDR_W'(HEADER_BYTES);
    localparam logic [ADDR_W-1:0] HEAP_A  = ADDR_W'(HEAP_BYTES);
    localparam logic [SZ_W:0]     SPLIT_M = (SZ_W + 1)'(HEADER_BYTES + 8);
    localparam logic [SZ_W-1:0]   SZ_HDR  = SZ_W'(HEADER_BYTES);
    localparam logic [SZ_W-1:0]   INIT_SZ = SZ_W'(HEAP_BYTES - HEADER_BYTES);
    localparam logic [CNT_W-1:0]  C_HDR   = CNT_W'(HEADER_BYTES);
    localparam logic [CNT_W-1:0]  C_FREE0 = CNT_W'(HEAP_BYTES - HEADER_BYTES);
    localparam logic [WORD_W-1:0] LAST_W  = WORD_W'(WORDS - 1);

    logic              op_reg;
    logic [SZ_W-1:0]   size_reg, bsz_reg, rounded;
    logic [OFF_W-1:0]  off_reg;
    logic [ADDR_W-1:0] cur_reg, next_cur, split_addr, free_addr, app_end;
    logic [WORD_W-1:0] clr_idx_reg;
    logic [CNT_W-1:0]  used_reg, used_next, free_reg, free_next;
    logic [BLK_W-1:0]  blk_reg, blk_next;
    logic [OFF_W-1:0]  pay_reg;
    logic              st_reg;
    logic [CNT_W-1:0]  rused_reg, rfree_reg;
    logic [BLK_W-1:0]  rblk_reg;
    logic              we, re;
    logic [WORD_W-1:0] waddr, raddr;
    logic [ENT_W-1:0]  wdata, rdata;
    logic [SZ_W-1:0]   rsize;
    logic              rfree;
    logic [CNT_W-1:0]  bsz_c, size_c, rsize_c;
    logic              finish;

    ffha_ram #(
        .WIDTH(ENT_W),
        .DEPTH(WORDS)
    ) u_hdr_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    // Header fields and derived addresses.
    assign rsize      = rdata[SZ_W-1:0];
    assign rfree      = rdata[SZ_W];
    assign rounded    = (SZ_W'(request_size) + SZ_W'(7)) & ~SZ_W'(7);
    assign next_cur   = cur_reg + ADDR_W'(rsize) + HDR_A;
    assign split_addr = cur_reg + HDR_A + ADDR_W'(size_reg);
    assign app_end    = cur_reg + ADDR_W'(size_reg) + HDR_A;
    assign free_addr  = ADDR_W'(off_reg) - HDR_A;
    assign bsz_c      = bsz_reg[CNT_W-1:0];
    assign size_c     = size_reg[CNT_W-1:0];
    assign rsize_c    = rsize[CNT_W-1:0];

    // Status toward the controller.
    always_comb
    begin
        sts            = '0;
        sts.clr_last   = (clr_idx_reg == LAST_W);
        sts.is_free_op = (op_reg == OP_FREE);
        sts.req_zero   = (size_reg == '0);
        sts.free_ok    = (ADDR_W'(off_reg) >= HDR_A) && (free_addr < HEAP_A);
        sts.fit        = rfree && (rsize >= size_reg);
        sts.split_ok   = ({1'b0, rsize} >= ({1'b0, size_reg} + SPLIT_M));
        sts.walk_end   = (next_cur >= HEAP_A);
        sts.append_ok  = (app_end <= HEAP_A);
    end

    // RAM port selection.
    always_comb
    begin
        we    = 1'b0;
        waddr = cur_reg[WORD_W+2:3];
        wdata = {1'b0, bsz_reg};
        re    = cmd.rd_cur | cmd.rd_off;
        raddr = cmd.rd_off ? free_addr[WORD_W+2:3] : cur_reg[WORD_W+2:3];
        if (cmd.clr)
        begin
            we    = 1'b1;
            waddr = clr_idx_reg;
            wdata = (clr_idx_reg == '0) ? {1'b1, INIT_SZ} : '0;
        end
        else if (cmd.wr_split)
        begin
            we    = (split_addr < HEAP_A);
            waddr = split_addr[WORD_W+2:3];
            wdata = {1'b1, bsz_reg - size_reg - SZ_HDR};
        end
        else if (cmd.wr_cur)
        begin
            we = 1'b1;
        end
        else if (cmd.wr_app)
        begin
            we    = 1'b1;
            wdata = {1'b0, size_reg};
        end
        else if (cmd.wr_free)
        begin
            we    = 1'b1;
            waddr = free_addr[WORD_W+2:3];
            wdata = {1'b1, rsize};
        end
    end

    // Statistics counter updates.
    always_comb
    begin
        used_next = used_reg;
        free_next = free_reg;
        blk_next  = blk_reg;
        if (cmd.wr_split)
        begin
            used_next = used_reg + C_HDR;
            free_next = free_reg - C_HDR;
            blk_next  = blk_reg + BLK_W'(1);
        end
        else if (cmd.wr_cur)
        begin
            used_next = used_reg + bsz_c;
            free_next = free_reg - bsz_c;
        end
        else if (cmd.wr_app)
        begin
            used_next = used_reg + size_c + C_HDR;
            free_next = free_reg - size_c - C_HDR;
            blk_next  = blk_reg + BLK_W'(1);
        end
        else if (cmd.wr_free)
        begin
            used_next = used_reg - rsize_c;
            free_next = free_reg + rsize_c;
        end
    end

    assign finish = cmd.wr_cur | cmd.wr_app | cmd.wr_free | cmd.fin_fail | cmd.fin_nop;

    // Control state: clear index and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
            used_reg    <= C_HDR;
            free_reg    <= C_FREE0;
            blk_reg     <= BLK_W'(1);
        end
        else
        begin
            if (cmd.clr)
            begin
                clr_idx_reg <= clr_idx_reg + WORD_W'(1);
            end
            used_reg <= used_next;
            free_reg <= free_next;
            blk_reg  <= blk_next;
        end
    end

    // Payload registers: request capture, walk pointer and result.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= operation;
            size_reg <= rounded;
            off_reg  <= release_offset;
            cur_reg  <= '0;
        end
        if (cmd.step)
        begin
            cur_reg <= next_cur;
        end
        if (cmd.take)
        begin
            bsz_reg <= rsize;
        end
        if (cmd.wr_split)
        begin
            bsz_reg <= size_reg;
        end
        if (finish)
        begin
            pay_reg   <= (cmd.wr_cur || cmd.wr_app) ? OFF_W'(cur_reg + HDR_A) : '0;
            st_reg    <= cmd.fin_fail ? ST_FAIL : ST_DONE;
            rused_reg <= used_next;
            rfree_reg <= free_next;
            rblk_reg  <= blk_next;
        end
    end

    assign payload_offset = pay_reg;
    assign status         = st_reg;
    assign bytes_used     = rused_reg;
    assign bytes_free     = rfree_reg;
    assign block_count    = rblk_reg;

endmodule

/* rtl/first_fit_heap_allocator.sv */
// Top level of the first-fit heap allocator with block splitting.
// Depends on ffha_pkg, ffha_ctrl and ffha_dpath.
//
//   channel | handshake            | fields
//   --------+----------------------+---------------------------------------------
//   input   | in_valid / in_ready  | operation, request_size, release_offset
//   output  | out_valid / out_ready| payload_offset, status, bytes_used,
//           |                      | bytes_free, block_count
//
// An allocate walks the header chain with one RAM read and one compare per header
// visited, plus a split write when the block is split; a free reads and rewrites
// one header, and a zero size or null free touches no header.
// After reset a clearing pass writes every header word (HEAP_BYTES/8 words,
// 8192 by default), during which in_ready stays low.
// A waiting result holds its registers; the next item is accepted and runs
// up to its final write, which waits until the output slot is free.
`timescale 1ns / 1ps

module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             operation,
    input  logic [REQ_W-1:0] request_size,
    input  logic [OFF_W-1:0] release_offset,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [OFF_W-1:0] payload_offset,
    output logic             status,
    output logic [CNT_W-1:0] bytes_used,
    output logic [CNT_W-1:0] bytes_free,
    output logic [BLK_W-1:0] block_count
);

    localparam logic [CNT_W-1:0] HEAP_C = CNT_W'(HEAP_BYTES);

    ffha_cmd_t cmd;
    ffha_sts_t sts;

    ffha_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffha_dpath #(
        .HEAP_BYTES  (HEAP_BYTES),
        .HEADER_BYTES(HEADER_BYTES)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .operation     (operation),
        .request_size  (request_size),
        .release_offset(release_offset),
        .payload_offset(payload_offset),
        .status        (status),
        .bytes_used    (bytes_used),
        .bytes_free    (bytes_free),
        .block_count   (block_count)
    );

    // Used plus free bytes always add up to the heap size.
    a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (CNT_W'(bytes_used + bytes_free) == HEAP_C))
        else $error("used and free byte counts do not add up to the heap size");

    // A failed allocate never carries an offset; offsets are word aligned.
    a_fail_null: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((status == ST_DONE || payload_offset == '0)
                       && payload_offset[2:0] == 3'd0))
        else $error("result offset is inconsistent with its status");

    // No input is taken while the clearing pass writes the header RAM.
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr |-> !in_ready)
        else $error("input accepted during the clearing pass");

endmodule

/* bench/first_fit_heap_allocator_tb.sv */
// Self-checking testbench for the first-fit heap allocator.
// Depends on ffha_pkg and the first_fit_heap_allocator RTL; a built-in heap
// predictor checks every transaction.
`timescale 1ns / 1ps

module first_fit_heap_allocator_tb;
    import ffha_pkg::*;

    localparam int HEAP      = HEAP_BYTES_DEF;
    localparam int HDR       = HEADER_BYTES_DEF;
    localparam int WORDS     = HEAP / 8;
    localparam int N_ITEMS   = 1250;
    localparam int QUIET_AT  = N_ITEMS - 120;
    localparam int HOLD_AT   = 300;
    localparam int HOLD_LEN  = 600;
    localparam longint LIMIT = 60_000_000;

    typedef struct {
        logic             op;
        logic [REQ_W-1:0] size;
        logic [OFF_W-1:0] offset;
    } heap_req_t;

    typedef struct {
        logic [OFF_W-1:0] payload;
        logic             stat;
        logic [CNT_W-1:0] used;
        logic [CNT_W-1:0] free_b;
        logic [BLK_W-1:0] blocks;
    } heap_resp_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic             operation;
    logic [REQ_W-1:0] request_size;
    logic [OFF_W-1:0] release_offset;
    logic             out_valid;
    logic             out_ready;
    logic [OFF_W-1:0] payload_offset;
    logic             status;
    logic [CNT_W-1:0] bytes_used;
    logic [CNT_W-1:0] bytes_free;
    logic [BLK_W-1:0] block_count;

    // Shadow copy of the heap headers and running statistics.
    bit [31:0] hdr_size [WORDS];
    bit        hdr_free [WORDS];
    bit [31:0] used_total;
    bit [31:0] free_total;
    bit [31:0] blocks_total;

    heap_req_t  pending_reqs[$];
    heap_resp_t expected_resps[$];
    logic [OFF_W-1:0] live_blocks[$];

    int     sent_count;
    int     recv_count;
    int     send_gap;
    int     recv_gap;
    int     hold_left;
    bit     hold_done;
    int     error_count;
    longint cycle_count = 0;

    first_fit_heap_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .request_size  (request_size),
        .release_offset(release_offset),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .payload_offset(payload_offset),
        .status        (status),
        .bytes_used    (bytes_used),
        .bytes_free    (bytes_free),
        .block_count   (block_count)
    );

    // Clock and reset.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Put the shadow heap into its reset state: one free block over the whole heap.
    task automatic heap_reset();
        for (int i = 0; i < WORDS; i++)
        begin
            hdr_size[i] = 0;
            hdr_free[i] = 1'b0;
        end
        hdr_size[0]  = HEAP - HDR;
        hdr_free[0]  = 1'b1;
        used_total   = HDR;
        free_total   = HEAP - HDR;
        blocks_total = 1;
    endtask

    function automatic void put_header(longint addr, bit [31:0] sz, bit is_free);
        if ((addr >> 3) < WORDS)
        begin
            hdr_size[addr >> 3] = sz;
            hdr_free[addr >> 3] = is_free;
        end
    endfunction

    // First-fit walk with split, falling back to an append after the last block.
    function automatic longint heap_allocate(bit [31:0] req);
        bit [31:0] rounded;
        bit [31:0] bsize;
        longint    cur;
        longint    last;
        bit        found;
        bit        have_last;
        cur = 0;
        last = 0;
        found = 1'b0;
        have_last = 1'b0;
        if (req == 0)
            return 0;
        rounded = (req + 7) & ~32'd7;
        while (cur < HEAP)
        begin
            if (hdr_free[cur >> 3] && hdr_size[cur >> 3] >= rounded)
            begin
                found = 1'b1;
                break;
            end
            last = cur;
            have_last = 1'b1;
            cur = cur + hdr_size[cur >> 3] + HDR;
        end
        if (found)
        begin
            bsize = hdr_size[cur >> 3];
            if (longint'(bsize) >= longint'(rounded) + HDR + 8)
            begin
                put_header(cur + HDR + rounded, bsize - rounded - HDR, 1'b1);
                bsize = rounded;
                used_total += HDR;
                free_total -= HDR;
                blocks_total += 1;
            end
            put_header(cur, bsize, 1'b0);
            used_total += bsize;
            free_total -= bsize;
            return cur + HDR;
        end
        if (have_last)
        begin
            cur = last + hdr_size[last >> 3] + HDR;
            if (cur + rounded + HDR > HEAP)
                return 0;
        end
        else
            cur = 0;
        put_header(cur, rounded, 1'b0);
        used_total += rounded + HDR;
        free_total -= rounded + HDR;
        blocks_total += 1;
        return cur + HDR;
    endfunction

    // Free without coalescing; null, sub-header and out-of-heap offsets are ignored.
    function automatic void heap_release(bit [31:0] off);
        longint addr;
        if (off == 0 || off < HDR)
            return;
        addr = longint'(off) - HDR;
        if (addr >= HEAP)
            return;
        used_total -= hdr_size[addr >> 3];
        free_total += hdr_size[addr >> 3];
        hdr_free[addr >> 3] = 1'b1;
    endfunction

    // Apply one accepted transaction to the shadow heap and queue its result.
    function automatic void predict_heap(heap_req_t r);
        heap_resp_t e;
        longint     pay;
        pay = 0;
        if (r.op == OP_ALLOC)
        begin
            pay = heap_allocate(r.size);
            if (pay != 0)
                live_blocks.push_back(pay[OFF_W-1:0]);
        end
        else
            heap_release(r.offset);
        e.payload = pay[OFF_W-1:0];
        e.stat    = (r.op == OP_ALLOC && pay == 0) ? ST_FAIL : ST_DONE;
        e.used    = used_total[CNT_W-1:0];
        e.free_b  = free_total[CNT_W-1:0];
        e.blocks  = blocks_total[BLK_W-1:0];
        expected_resps.push_back(e);
    endfunction

    task automatic queue_req(logic op, logic [REQ_W-1:0] sz, logic [OFF_W-1:0] off);
        heap_req_t r;
        r.op = op;
        r.size = sz;
        r.offset = off;
        while (pending_reqs.size() >= 4)
            @(posedge clk);
        pending_reqs.push_back(r);
    endtask

    function automatic logic [OFF_W-1:0] pick_live();
        int idx;
        logic [OFF_W-1:0] off;
        if (live_blocks.size() == 0)
            return OFF_W'($urandom_range(8, 65535));
        idx = int'($urandom_range(0, live_blocks.size() - 1));
        off = live_blocks[idx];
        live_blocks.delete(idx);
        return off;
    endfunction

    // Stimulus: directed corner cases, then random allocate/free traffic.
    initial
    begin
        int pick;
        logic [REQ_W-1:0] sz;
        logic [OFF_W-1:0] off;
        heap_reset();
        @(posedge rst_n);
        queue_req(OP_ALLOC, 16'd0, 16'hFFFF);   // zero size
        queue_req(OP_ALLOC, 16'd1, 16'd0);
        queue_req(OP_ALLOC, 16'd8, 16'd0);
        queue_req(OP_ALLOC, 16'd9, 16'd0);
        queue_req(OP_FREE, 16'hFFFF, 16'd0);     // null free
        queue_req(OP_FREE, 16'd0, 16'd5);        // below header
        queue_req(OP_FREE, 16'd0, 16'd7);
        queue_req(OP_FREE, 16'd0, 16'd8);        // first block
        queue_req(OP_FREE, 16'd0, 16'd8);        // double free
        queue_req(OP_FREE, 16'd0, 16'hFFFF);     // stray entry at the heap top
        queue_req(OP_ALLOC, 16'hFFFF, 16'd0);    // no fit
        queue_req(OP_ALLOC, 16'd4000, 16'd0);
        queue_req(OP_FREE, 16'd0, 16'd27);       // low bits ignored
        queue_req(OP_ALLOC, 16'd16, 16'd0);
        queue_req(OP_ALLOC, 16'd65000, 16'd0);
        queue_req(OP_ALLOC, 16'd30000, 16'd0);
        queue_req(OP_ALLOC, 16'd30000, 16'd0);
        queue_req(OP_ALLOC, 16'd8, 16'd0);
        queue_req(OP_FREE, 16'd0, 16'd16);
        queue_req(OP_ALLOC, 16'd24, 16'd0);
        for (int i = 20; i < N_ITEMS; i++)
        begin
            pick = int'($urandom_range(0, 99));
            if (pick < 55)
            begin
                pick = int'($urandom_range(0, 99));
                if (pick < 70)
                    sz = REQ_W'($urandom_range(1, 2048));
                else if (pick < 85)
                    sz = REQ_W'($urandom_range(1, 64));
                else if (pick < 95)
                    sz = REQ_W'($urandom_range(0, 65535));
                else
                    sz = '0;
                queue_req(OP_ALLOC, sz, OFF_W'($urandom_range(0, 65535)));
            end
            else
            begin
                pick = int'($urandom_range(0, 99));
                if (pick < 70)
                    off = pick_live();
                else if (pick < 80)
                    off = '0;
                else if (pick < 90)
                    off = OFF_W'($urandom_range(1, 7));
                else
                    off = OFF_W'($urandom_range(0, 65535));
                queue_req(OP_FREE, REQ_W'($urandom_range(0, 65535)), off);
            end
        end
    end

    // Input driver: holds each transaction until accepted, with random idle bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid       <= 1'b0;
            operation      <= OP_ALLOC;
            request_size   <= '0;
            release_offset <= '0;
            send_gap       <= 0;
            sent_count     <= 0;
        end
        else if (!(in_valid && !in_ready))
        begin
            if (in_valid)
            begin
                predict_heap('{operation, request_size, release_offset});
                sent_count <= sent_count + 1;
            end
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                heap_req_t r;
                r = pending_reqs.pop_front();
                in_valid       <= 1'b1;
                operation      <= r.op;
                request_size   <= r.size;
                release_offset <= r.offset;
                if (sent_count < QUIET_AT && $urandom_range(0, 7) == 0)
                    send_gap <= int'($urandom_range(1, 12));
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Output monitor: checks every result and drives out_ready with stalls and one long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            recv_gap    <= 0;
            hold_left   <= 0;
            hold_done   <= 1'b0;
            recv_count  <= 0;
            error_count <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                heap_resp_t e;
                recv_count <= recv_count + 1;
                if (expected_resps.size() == 0)
                begin
                    $error("unexpected result transaction, payload_offset %0d", payload_offset);
                    error_count <= error_count + 1;
                end
                else
                begin
                    e = expected_resps.pop_front();
                    if (payload_offset !== e.payload)
                        $error("payload_offset: expected %0d, got %0d", e.payload, payload_offset);
                    if (status !== e.stat)
                        $error("status: expected %0d, got %0d", e.stat, status);
                    if (bytes_used !== e.used)
                        $error("bytes_used: expected %0d, got %0d", e.used, bytes_used);
                    if (bytes_free !== e.free_b)
                        $error("bytes_free: expected %0d, got %0d", e.free_b, bytes_free);
                    if (block_count !== e.blocks)
                        $error("block_count: expected %0d, got %0d", e.blocks, block_count);
                    if (payload_offset !== e.payload || status !== e.stat
                        || bytes_used !== e.used || bytes_free !== e.free_b
                        || block_count !== e.blocks)
                        error_count <= error_count + 1;
                end
            end
            if (!hold_done && recv_count >= HOLD_AT)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_LEN;
                out_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap  <= recv_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (recv_count < QUIET_AT && $urandom_range(0, 7) == 0)
                    recv_gap <= int'($urandom_range(1, 12));
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("first_fit_heap_allocator_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        @(posedge rst_n);
        wait (sent_count == N_ITEMS && expected_resps.size() == 0);
        repeat (200) @(posedge clk);
        if (error_count == 0 && expected_resps.size() == 0)
            $display("first_fit_heap_allocator_tb: done, clean");
        else
            $display("first_fit_heap_allocator_tb: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
rtl/ffha_pkg.sv
rtl/ffha_ram.sv
rtl/ffha_ctrl.sv
rtl/ffha_dpath.sv
rtl/first_fit_heap_allocator.sv
bench/first_fit_heap_allocator_tb.sv
